// ----- hdl/tcw_pkg.sv -----
// Package for the text console writer: geometry, field widths, codes and the
// command/status structs shared by controller and datapath. No dependencies.
package tcw_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELL_COUNT  = ROWS * COLUMNS;
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    localparam int MODE_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int ROW_W       = 5;
    localparam int COL_W       = 7;
    localparam int CELL_W      = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

    localparam logic [ADDR_W-1:0] COL_STEP      = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ROW_W-1:0]  ROW_LIMIT     = ROW_W'(ROWS);
    localparam logic [COL_W-1:0]  COL_LIMIT     = COL_W'(COLUMNS);
    localparam logic [COL_W-1:0]  COL_LAST      = COL_W'(COLUMNS - 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE,
        MODE_CLEAR,
        MODE_READ,
        MODE_NOP
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TEXT_ATTR,
        REG_BLANK_ATTR
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SWEEP_INIT,
        SWEEP_CLEAR,
        SWEEP_SCROLL
    } sweep_kind_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_INIT_END,
        ST_IDLE,
        ST_DISPATCH,
        ST_SCROLL,
        ST_SCROLL_END,
        ST_CLEAR,
        ST_CLEAR_END,
        ST_STORE,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        latch_item;
        logic        cell_zero;
        logic        nl_apply;
        logic        sweep_start;
        logic        sweep_run;
        sweep_kind_t sweep_kind;
        logic        scroll_cursor;
        logic        home_cursor;
        logic        store;
        logic        read_issue;
        logic        cell_capture;
        logic        out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  is_nl;
        logic  scroll_due;
        logic  sweep_last;
        logic  out_free;
    } dp_status_t;

endpackage

// ----- hdl/tcw_ctrl.sv -----
// Controller state machine for the text console writer.
// Depends on tcw_pkg for states, modes and the command/status structs.
module tcw_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  tcw_pkg::dp_status_t status,
    output tcw_pkg::ctrl_cmd_t  cmd,
    output logic               in_stall
);

    tcw_pkg::state_t state_reg;
    tcw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcw_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != tcw_pkg::ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.sweep_kind = tcw_pkg::SWEEP_INIT;
        case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                cmd.sweep_run  = 1'b1;
                cmd.sweep_kind = tcw_pkg::SWEEP_INIT;
                if (status.sweep_last)
                begin
                    state_next = tcw_pkg::ST_INIT_END;
                end
            end
            tcw_pkg::ST_INIT_END:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = tcw_pkg::ST_DISPATCH;
                end
            end
            tcw_pkg::ST_DISPATCH:
            begin
                cmd.cell_zero = 1'b1;
                case (status.mode)
                    tcw_pkg::MODE_WRITE:
                    begin
                        cmd.nl_apply = status.is_nl;
                        if (status.scroll_due)
                        begin
                            cmd.sweep_start = 1'b1;
                            state_next      = tcw_pkg::ST_SCROLL;
                        end
                        else if (status.is_nl)
                        begin
                            state_next = tcw_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = tcw_pkg::ST_STORE;
                        end
                    end
                    tcw_pkg::MODE_CLEAR:
                    begin
                        cmd.sweep_start = 1'b1;
                        state_next      = tcw_pkg::ST_CLEAR;
                    end
                    tcw_pkg::MODE_READ:
                    begin
                        cmd.read_issue = 1'b1;
                        state_next     = tcw_pkg::ST_READ_WAIT;
                    end
                    default:
                    begin
                        state_next = tcw_pkg::ST_DONE;
                    end
                endcase
            end
            tcw_pkg::ST_SCROLL:
            begin
                cmd.sweep_run  = 1'b1;
                cmd.sweep_kind = tcw_pkg::SWEEP_SCROLL;
                if (status.sweep_last)
                begin
                    state_next = tcw_pkg::ST_SCROLL_END;
                end
            end
            tcw_pkg::ST_SCROLL_END:
            begin
                cmd.scroll_cursor = 1'b1;
                state_next = status.is_nl ? tcw_pkg::ST_DONE : tcw_pkg::ST_STORE;
            end
            tcw_pkg::ST_CLEAR:
            begin
                cmd.sweep_run  = 1'b1;
                cmd.sweep_kind = tcw_pkg::SWEEP_CLEAR;
                if (status.sweep_last)
                begin
                    state_next = tcw_pkg::ST_CLEAR_END;
                end
            end
            tcw_pkg::ST_CLEAR_END:
            begin
                cmd.home_cursor = 1'b1;
                state_next      = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_READ_WAIT:
            begin
                cmd.cell_capture = 1'b1;
                state_next       = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = tcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/tcw_datapath.sv -----
// Datapath for the text console writer: screen memory, cursor, sweep counter,
// attribute registers and output word register. Depends on tcw_pkg.
module tcw_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcw_pkg::ctrl_cmd_t            cmd,
    output tcw_pkg::dp_status_t           status,
    input  logic [tcw_pkg::MODE_W-1:0]    mode,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::ROW_W-1:0]     read_row,
    input  logic [tcw_pkg::COL_W-1:0]     read_col,
    input  logic                          cfg_write,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcw_pkg::ATTR_W-1:0]    cfg_data,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [tcw_pkg::CELL_W-1:0]    cell_value,
    output logic [tcw_pkg::ROW_W-1:0]     cursor_row,
    output logic [tcw_pkg::COL_W-1:0]     cursor_col
);

    logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];

    tcw_pkg::mode_t             mode_reg;
    logic [tcw_pkg::CHAR_W-1:0] char_reg;
    logic [tcw_pkg::ROW_W-1:0]  rrow_reg;
    logic [tcw_pkg::COL_W-1:0]  rcol_reg;

    logic [tcw_pkg::ROW_W-1:0]  row_reg;
    logic [tcw_pkg::ROW_W-1:0]  row_next;
    logic [tcw_pkg::COL_W-1:0]  col_reg;
    logic [tcw_pkg::COL_W-1:0]  col_next;

    logic [tcw_pkg::ADDR_W-1:0] sweep_reg;
    logic                       wr_en_reg;
    logic [tcw_pkg::ADDR_W-1:0] wr_addr_reg;
    tcw_pkg::sweep_kind_t       wr_kind_reg;
    logic [tcw_pkg::CELL_W-1:0] rdata_reg;
    logic [tcw_pkg::CELL_W-1:0] cell_reg;

    logic [tcw_pkg::ATTR_W-1:0] text_attr_reg;
    logic [tcw_pkg::ATTR_W-1:0] blank_attr_reg;

    logic                       out_valid_reg;
    logic [tcw_pkg::CELL_W-1:0] out_cell_reg;
    logic [tcw_pkg::ROW_W-1:0]  out_row_reg;
    logic [tcw_pkg::COL_W-1:0]  out_col_reg;

    logic                       is_nl;
    logic                       read_in_range;
    logic [tcw_pkg::ADDR_W-1:0] cursor_addr;
    logic [tcw_pkg::ADDR_W-1:0] read_addr;
    logic [tcw_pkg::ADDR_W-1:0] sweep_rd_addr;
    logic [tcw_pkg::ADDR_W-1:0] rd_addr;
    logic [tcw_pkg::CELL_W-1:0] sweep_data;

    assign is_nl         = (char_reg == tcw_pkg::NEWLINE_CODE);
    assign read_in_range = (rrow_reg < tcw_pkg::ROW_LIMIT) && (rcol_reg < tcw_pkg::COL_LIMIT);
    assign cursor_addr   = tcw_pkg::ADDR_W'(tcw_pkg::ADDR_W'(row_reg) * tcw_pkg::COL_STEP
                                            + tcw_pkg::ADDR_W'(col_reg));
    assign read_addr     = read_in_range
                         ? tcw_pkg::ADDR_W'(tcw_pkg::ADDR_W'(rrow_reg) * tcw_pkg::COL_STEP
                                            + tcw_pkg::ADDR_W'(rcol_reg))
                         : '0;
    assign sweep_rd_addr = (sweep_reg < tcw_pkg::LAST_ROW_BASE)
                         ? tcw_pkg::ADDR_W'(sweep_reg + tcw_pkg::COL_STEP)
                         : '0;
    assign rd_addr       = cmd.read_issue ? read_addr : sweep_rd_addr;

    assign status.mode       = mode_reg;
    assign status.is_nl      = is_nl;
    assign status.scroll_due = (tcw_pkg::ROW_W'(row_reg + tcw_pkg::ROW_W'(is_nl))
                                >= tcw_pkg::ROW_LIMIT);
    assign status.sweep_last = (sweep_reg == tcw_pkg::LAST_CELL);
    assign status.out_free   = !out_valid_reg || !out_stall;

    // Moved rows keep the character byte and take the text attribute.
    always_comb
    begin
        case (wr_kind_reg)
            tcw_pkg::SWEEP_SCROLL:
            begin
                if (wr_addr_reg < tcw_pkg::LAST_ROW_BASE)
                begin
                    sweep_data = {text_attr_reg, rdata_reg[tcw_pkg::CHAR_W-1:0]};
                end
                else
                begin
                    sweep_data = {blank_attr_reg, tcw_pkg::SPACE_CODE};
                end
            end
            tcw_pkg::SWEEP_CLEAR:
            begin
                sweep_data = {blank_attr_reg, tcw_pkg::SPACE_CODE};
            end
            tcw_pkg::SWEEP_INIT:
            begin
                sweep_data = {tcw_pkg::ATTR_RESET, tcw_pkg::SPACE_CODE};
            end
            default:
            begin
                sweep_data = {tcw_pkg::ATTR_RESET, tcw_pkg::SPACE_CODE};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
        if (wr_en_reg)
        begin
            mem[wr_addr_reg] <= sweep_data;
        end
        else if (cmd.store)
        begin
            mem[cursor_addr] <= {text_attr_reg, char_reg};
        end
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cmd.nl_apply)
        begin
            row_next = tcw_pkg::ROW_W'(row_reg + 1'b1);
            col_next = '0;
        end
        else if (cmd.scroll_cursor)
        begin
            if (row_reg != '0)
            begin
                row_next = tcw_pkg::ROW_W'(row_reg - 1'b1);
            end
            col_next = '0;
        end
        else if (cmd.home_cursor)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (cmd.store)
        begin
            if (col_reg == tcw_pkg::COL_LAST)
            begin
                row_next = tcw_pkg::ROW_W'(row_reg + 1'b1);
                col_next = '0;
            end
            else
            begin
                col_next = tcw_pkg::COL_W'(col_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg        <= '0;
            col_reg        <= '0;
            sweep_reg      <= '0;
            wr_en_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            text_attr_reg  <= tcw_pkg::ATTR_RESET;
            blank_attr_reg <= tcw_pkg::ATTR_RESET;
        end
        else
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            wr_en_reg <= cmd.sweep_run;
            if (cmd.sweep_start)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.sweep_run)
            begin
                sweep_reg <= (sweep_reg == tcw_pkg::LAST_CELL)
                           ? '0 : tcw_pkg::ADDR_W'(sweep_reg + 1'b1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                case (tcw_pkg::cfg_reg_t'(cfg_index))
                    tcw_pkg::REG_TEXT_ATTR:  text_attr_reg  <= cfg_data;
                    tcw_pkg::REG_BLANK_ATTR: blank_attr_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= sweep_reg;
        wr_kind_reg <= cmd.sweep_kind;
        if (cmd.latch_item)
        begin
            mode_reg <= tcw_pkg::mode_t'(mode);
            char_reg <= char_code;
            rrow_reg <= read_row;
            rcol_reg <= read_col;
        end
        if (cmd.cell_zero)
        begin
            cell_reg <= '0;
        end
        else if (cmd.cell_capture)
        begin
            cell_reg <= read_in_range ? rdata_reg : '0;
        end
        if (cmd.out_load)
        begin
            out_cell_reg <= cell_reg;
            out_row_reg  <= row_reg;
            out_col_reg  <= col_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_value = out_cell_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;

endmodule

// ----- hdl/text_console_writer_unit.sv -----
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// Input channel (in_valid/in_stall) takes one word: mode, char_code,
// read_row, read_col. Output channel (out_valid/out_stall) returns one word
// per input word: cell_value, cursor_row, cursor_col. The config channel
// (cfg_valid/cfg_ready) writes text attribute (index 0) or blank attribute
// (index 1); cfg_ready is always high.
// Scroll and clear sweep the 2000-cell screen memory through its single
// write port, one cell a cycle. One word is in work at a time; the next
// can be taken in the same cycle in which the result first sits in the
// output register.
// After reset the block sweeps all 2000 cells to blanks with
// in_stall high; config writes are taken during that sweep.
// With out_stall high the result holds in the output register; the block
// finishes the next word and waits until the register frees.
module text_console_writer_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tcw_pkg::MODE_W-1:0]        mode,
    input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
    input  logic [tcw_pkg::ROW_W-1:0]         read_row,
    input  logic [tcw_pkg::COL_W-1:0]         read_col,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tcw_pkg::CELL_W-1:0]        cell_value,
    output logic [tcw_pkg::ROW_W-1:0]         cursor_row,
    output logic [tcw_pkg::COL_W-1:0]         cursor_col,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tcw_pkg::ATTR_W-1:0]        cfg_data
);

    tcw_pkg::ctrl_cmd_t  cmd;
    tcw_pkg::dp_status_t status;
    logic                cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    tcw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    tcw_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .mode       (mode),
        .char_code  (char_code),
        .read_row   (read_row),
        .read_col   (read_col),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .cell_value (cell_value),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col)
    );

endmodule

// ----- hdl/tcw_checker.sv -----
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg for field widths and screen geometry.
module tcw_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [tcw_pkg::CELL_W-1:0]      cell_value,
    input logic [tcw_pkg::ROW_W-1:0]       cursor_row,
    input logic [tcw_pkg::COL_W-1:0]       cursor_col
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(cell_value)))
        else $error("stalled output word changed or dropped");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((cursor_row <= tcw_pkg::ROW_LIMIT) && (cursor_col < tcw_pkg::COL_LIMIT)))
        else $error("cursor outside screen range");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second word taken while one is in work");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result word without a word in work");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (.*);

// ----- test/console_monitor.sv -----
`timescale 1ns / 100ps
// Checker for the text console writer: follows the input, result and register
// write channels, predicts every result word and compares it field by field.
// Depends on tcw_pkg.
module console_monitor
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [tcw_pkg::MODE_W-1:0]      mode,
    input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
    input  logic [tcw_pkg::ROW_W-1:0]       read_row,
    input  logic [tcw_pkg::COL_W-1:0]       read_col,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [tcw_pkg::CELL_W-1:0]      cell_value,
    input  logic [tcw_pkg::ROW_W-1:0]       cursor_row,
    input  logic [tcw_pkg::COL_W-1:0]       cursor_col,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcw_pkg::ATTR_W-1:0]      cfg_data,
    output int                              outstanding,
    output int                              fail_count
);

    import tcw_pkg::*;

    typedef struct packed {
        logic [CELL_W-1:0] cell_bits;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } console_word_t;

    logic [CELL_W-1:0] screen [CELL_COUNT];
    logic [ATTR_W-1:0] text_attr;
    logic [ATTR_W-1:0] blank_attr;
    int                cur_row;
    int                cur_col;
    console_word_t     pending_words [$];
    console_word_t     due_word;
    int                mismatches;
    int                word_index;

    function void wipe_screen();
        for (int k = 0; k < CELL_COUNT; k++)
        begin
            screen[ADDR_W'(k)] = {blank_attr, SPACE_CODE};
        end
        cur_row = 0;
        cur_col = 0;
    endfunction

    function void roll_up();
        for (int k = 0; k < (ROWS - 1) * COLUMNS; k++)
        begin
            screen[ADDR_W'(k)] = {text_attr, screen[ADDR_W'(k + COLUMNS)][CHAR_W-1:0]};
        end
        for (int k = (ROWS - 1) * COLUMNS; k < CELL_COUNT; k++)
        begin
            screen[ADDR_W'(k)] = {blank_attr, SPACE_CODE};
        end
        if (cur_row > 0)
        begin
            cur_row--;
        end
        cur_col = 0;
    endfunction

    function void put_char(logic [CHAR_W-1:0] ch);
        logic line_feed;
        line_feed = (ch == NEWLINE_CODE);
        if (line_feed)
        begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= ROWS)
        begin
            roll_up();
        end
        if (!line_feed)
        begin
            if (cur_row < ROWS && cur_col < COLUMNS)
            begin
                screen[ADDR_W'(cur_row * COLUMNS + cur_col)] = {text_attr, ch};
            end
            cur_col++;
            if (cur_col >= COLUMNS)
            begin
                cur_col = 0;
                cur_row++;
            end
        end
    endfunction

    function console_word_t next_console_word(logic [MODE_W-1:0] op,
                                              logic [CHAR_W-1:0] ch,
                                              logic [ROW_W-1:0] row_sel,
                                              logic [COL_W-1:0] col_sel);
        console_word_t w;
        w.cell_bits = '0;
        case (mode_t'(op))
            MODE_WRITE: put_char(ch);
            MODE_CLEAR: wipe_screen();
            MODE_READ:
            begin
                if (row_sel < ROW_LIMIT && col_sel < COL_LIMIT)
                begin
                    w.cell_bits = screen[ADDR_W'(int'(row_sel) * COLUMNS + int'(col_sel))];
                end
            end
            default: ;
        endcase
        w.row = ROW_W'(cur_row);
        w.col = COL_W'(cur_col);
        return w;
    endfunction

    task note_failure(string msg);
        mismatches++;
        $display("ERROR %s", msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attr  = ATTR_RESET;
            blank_attr = ATTR_RESET;
            wipe_screen();
            pending_words.delete();
            mismatches = 0;
            word_index = 0;
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TEXT_ATTR)
                begin
                    text_attr = cfg_data;
                end
                else if (cfg_index == REG_BLANK_ATTR)
                begin
                    blank_attr = cfg_data;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (pending_words.size() == 0)
                begin
                    note_failure($sformatf("word with nothing expected: cell %h row %0d col %0d",
                                           cell_value, cursor_row, cursor_col));
                end
                else
                begin
                    due_word = pending_words.pop_front();
                    if (cell_value !== due_word.cell_bits)
                    begin
                        note_failure($sformatf("word %0d cell_value %h, expected %h",
                                               word_index, cell_value, due_word.cell_bits));
                    end
                    if (cursor_row !== due_word.row)
                    begin
                        note_failure($sformatf("word %0d cursor_row %0d, expected %0d",
                                               word_index, cursor_row, due_word.row));
                    end
                    if (cursor_col !== due_word.col)
                    begin
                        note_failure($sformatf("word %0d cursor_col %0d, expected %0d",
                                               word_index, cursor_col, due_word.col));
                    end
                    word_index++;
                end
            end
            if (in_valid && !in_stall)
            begin
                pending_words.push_back(next_console_word(mode, char_code, read_row, read_col));
            end
            outstanding <= pending_words.size();
            fail_count  <= mismatches;
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for text_console_writer_unit: clock, reset, stimulus, random
// stalls and the verdict. Depends on tcw_pkg, the block and console_monitor.
module tb_top;

    import tcw_pkg::*;

    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int PHASES      = 7;
    localparam int PHASE_WORDS = 205;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [MODE_W-1:0] mode = '0;
    logic [CHAR_W-1:0] char_code = '0;
    logic [ROW_W-1:0]  read_row = '0;
    logic [COL_W-1:0]  read_col = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    cfg_reg_t          cfg_index = REG_TEXT_ATTR;
    logic [ATTR_W-1:0] cfg_data = '0;

    logic calm = 1'b0;
    int   outstanding;
    int   fail_count;
    int   words_sent = 0;
    int   cycle_count = 0;

    text_console_writer_unit dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .char_code  (char_code),
        .read_row   (read_row),
        .read_col   (read_col),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_value (cell_value),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    console_monitor monitor
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .char_code   (char_code),
        .read_row    (read_row),
        .read_col    (read_col),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cell_value  (cell_value),
        .cursor_row  (cursor_row),
        .cursor_col  (cursor_col),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 22);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL text_console_writer_unit");
            $finish;
        end
    end

    task automatic issue_word(input mode_t op, input logic [CHAR_W-1:0] ch,
                              input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 22)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= op;
        char_code <= ch;
        read_row  <= r;
        read_col  <= c;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    task automatic write_attributes(input logic [ATTR_W-1:0] text_a,
                                    input logic [ATTR_W-1:0] blank_a);
        cfg_valid <= 1'b1;
        cfg_index <= REG_TEXT_ATTR;
        cfg_data  <= text_a;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= REG_BLANK_ATTR;
        cfg_data  <= blank_a;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic probe_cell();
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        r = ($urandom_range(0, 99) < 85) ? ROW_W'($urandom_range(0, ROWS - 1))
                                         : ROW_W'($urandom_range(0, 31));
        c = ($urandom_range(0, 99) < 85) ? COL_W'($urandom_range(0, COLUMNS - 1))
                                         : COL_W'($urandom_range(0, 127));
        issue_word(MODE_READ, CHAR_W'($urandom_range(0, 255)), r, c);
    endtask

    function automatic logic [CHAR_W-1:0] plain_char();
        logic [CHAR_W-1:0] ch;
        do ch = CHAR_W'($urandom_range(0, 255)); while (ch == NEWLINE_CODE);
        return ch;
    endfunction

    initial
    begin
        int phase;
        int goal;
        int pick;
        int n;
        int nl_pct;
        logic [ATTR_W-1:0] text_a;
        logic [ATTR_W-1:0] blank_a;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (in_stall);

        write_attributes(8'h00, 8'hFF);
        issue_word(MODE_READ, 8'h00, 5'd0, 7'd0);
        issue_word(MODE_READ, 8'hFF, 5'd24, 7'd79);
        issue_word(MODE_READ, 8'h00, 5'd31, 7'd127);
        issue_word(MODE_READ, 8'h00, 5'd25, 7'd0);
        issue_word(MODE_READ, 8'h00, 5'd0, 7'd80);
        issue_word(MODE_WRITE, 8'h00, 5'd0, 7'd0);
        issue_word(MODE_WRITE, 8'hFF, 5'd31, 7'd127);
        issue_word(MODE_WRITE, NEWLINE_CODE, 5'd0, 7'd0);
        issue_word(MODE_WRITE, 8'h41, 5'd0, 7'd0);
        issue_word(MODE_NOP, 8'hFF, 5'd31, 7'd127);
        issue_word(MODE_READ, 8'h00, 5'd0, 7'd1);
        issue_word(MODE_READ, 8'h00, 5'd1, 7'd0);
        issue_word(MODE_CLEAR, 8'h00, 5'd0, 7'd0);
        issue_word(MODE_READ, 8'h00, 5'd0, 7'd0);
        issue_word(MODE_READ, 8'h00, 5'd24, 7'd79);
        wait_for_results();
        write_attributes(8'hFF, 8'h00);
        issue_word(MODE_WRITE, 8'h80, 5'd0, 7'd0);
        issue_word(MODE_WRITE, NEWLINE_CODE, 5'd0, 7'd0);
        issue_word(MODE_WRITE, NEWLINE_CODE, 5'd0, 7'd0);
        issue_word(MODE_READ, 8'h00, 5'd0, 7'd0);
        issue_word(MODE_CLEAR, 8'h00, 5'd0, 7'd0);
        issue_word(MODE_READ, 8'h00, 5'd12, 7'd40);

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_for_results();
            case (phase % 4)
                0:
                begin
                    text_a  = 8'hFF;
                    blank_a = 8'h00;
                end
                2:
                begin
                    text_a  = 8'h00;
                    blank_a = 8'hFF;
                end
                default:
                begin
                    text_a  = ATTR_W'($urandom_range(0, 255));
                    blank_a = ATTR_W'($urandom_range(0, 255));
                end
            endcase
            write_attributes(text_a, blank_a);
            calm <= (phase == 3);
            nl_pct = (phase % 3 == 0) ? 1 : ((phase % 3 == 1) ? 3 : 8);
            goal = words_sent + PHASE_WORDS;
            while (words_sent < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    n = $urandom_range(1, 100);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 99) < nl_pct)
                        begin
                            issue_word(MODE_WRITE, NEWLINE_CODE, '0, '0);
                        end
                        else
                        begin
                            issue_word(MODE_WRITE, CHAR_W'($urandom_range(0, 255)),
                                       ROW_W'($urandom_range(0, 31)),
                                       COL_W'($urandom_range(0, 127)));
                        end
                    end
                end
                else if (pick < 68)
                begin
                    n = $urandom_range(1, 8);
                    repeat (n) probe_cell();
                end
                else if (pick < 74)
                begin
                    // fill one whole line from column 0, then hit a scroll if the wrap left one pending
                    issue_word(MODE_WRITE, NEWLINE_CODE, '0, '0);
                    repeat (COLUMNS) issue_word(MODE_WRITE, plain_char(), '0, '0);
                    case ($urandom_range(0, 2))
                        0: issue_word(MODE_WRITE, NEWLINE_CODE, '0, '0);
                        1: probe_cell();
                        default: issue_word(MODE_NOP, plain_char(), '0, '0);
                    endcase
                    issue_word(MODE_WRITE, plain_char(), '0, '0);
                end
                else if (pick < 78)
                begin
                    n = $urandom_range(1, 5);
                    repeat (n) issue_word(MODE_WRITE, NEWLINE_CODE, '0, '0);
                end
                else if (pick < 80)
                begin
                    issue_word(MODE_CLEAR, CHAR_W'($urandom_range(0, 255)), '0, '0);
                end
                else if (pick < 86)
                begin
                    issue_word(MODE_NOP, CHAR_W'($urandom_range(0, 255)),
                               ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
                end
                else
                begin
                    issue_word(mode_t'(MODE_W'($urandom_range(0, 3))),
                               CHAR_W'($urandom_range(0, 255)),
                               ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
                end
            end
        end

        wait_for_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS text_console_writer_unit");
        end
        else
        begin
            $display("FAIL text_console_writer_unit");
        end
        $finish;
    end

endmodule
